@@ hdl/ukt_pkg.sv @@
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared types and codes for the unique key table with cursor.
// ----------------------------------------------------------------------------
package ukt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_FIND = 2'd2,
        CMD_SEEK = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] packed_count;
        logic [7:0] connect_score;
        logic [7:0] off_plan_count;
        logic [7:0] imagine_value;
    } t_in_word;

    typedef struct packed {
        t_status    status;
        logic [5:0] entry_index;
        logic [7:0] out_packed;
        logic [7:0] out_connect;
        logic [7:0] out_off_plan;
        logic [7:0] out_imagine;
    } t_out_word;

    typedef struct packed {
        logic shift;
        logic insert;
    } t_ring_ctl;

endpackage

@@ hdl/ukt_cell.sv @@
// ----------------------------------------------------------------------------
// ukt_cell
// One table entry; takes its neighbor's key on every shift.
// ----------------------------------------------------------------------------
module ukt_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [KEY_BITS-1:0] i_key,
    output logic [KEY_BITS-1:0] o_key
);

    logic [KEY_BITS-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_key;
        end
    end

    assign o_key = r_key;

endmodule

@@ hdl/ukt_ring.sv @@
// ----------------------------------------------------------------------------
// ukt_ring
// Circular chain of entry cells; the head cell is presented to the
// controller and the tail takes either the head or a new key.
// ----------------------------------------------------------------------------
module ukt_ring
    import ukt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  t_ring_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_ins_key,
    output logic [KEY_BITS-1:0] o_head
);

    logic [KEY_BITS-1:0] w_cell [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_feed;

        if (g == CAPACITY - 1) begin : g_tail
            assign w_feed = i_ctl.insert ? i_ins_key : w_cell[0];
        end else begin : g_body
            assign w_feed = w_cell[g+1];
        end

        ukt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_key   (w_feed),
            .o_key   (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

@@ hdl/unique_key_table_with_cursor.sv @@
// ----------------------------------------------------------------------------
// unique_key_table_with_cursor
// Table of distinct four-field keys with a round-robin cursor.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+-----------------------
//  command  | start / busy       | i_word   (t_in_word)
//  result   | o_done (strobe)    | o_result (t_out_word)
//
//  Each command rotates the whole cell ring once while busy, then the result
//  strobes for one cycle, in which the next command may start. A non-add
//  command on an empty table answers in the cycle after it is taken. Reset
//  clears the entry count, cursor and control; cell contents stay undefined
//  until added. The receiver cannot stall; every result is taken in its
//  strobe cycle.
// ----------------------------------------------------------------------------
module unique_key_table_with_cursor
    import ukt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int FIELD_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = 4 * FIELD_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_cursor, n_cursor;
    logic [IW-1:0]   r_step, n_step;
    logic [IW-1:0]   r_pos, n_pos;
    t_cmd            r_cmd, n_cmd;
    logic [KW-1:0]   r_key, n_key;
    logic            r_found, n_found;
    logic [IW-1:0]   r_hit_idx, n_hit_idx;
    logic [KW-1:0]   r_hit_key, n_hit_key;
    logic            r_done, n_done;
    t_out_word       r_out, n_out;

    logic [KW-1:0]   w_in_key;
    logic [KW-1:0]   w_head;
    t_ring_ctl       w_ctl;
    logic            w_in_range;
    logic            w_hit;
    logic            w_found;
    logic [IW-1:0]   w_idx;
    logic [KW-1:0]   w_fkey;
    logic            w_last;
    logic [CW-1:0]   w_pos_inc;

    assign w_in_key = {FIELD_BITS'(i_word.imagine_value), FIELD_BITS'(i_word.off_plan_count),
                       FIELD_BITS'(i_word.connect_score), FIELD_BITS'(i_word.packed_count)};

    ukt_ring #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_ins_key (r_key),
        .o_head    (w_head)
    );

    always_comb begin
        w_in_range = CW'(r_step) < r_count;
        if (r_cmd == CMD_NEXT) begin
            w_hit = (r_step == r_pos);
        end else begin
            w_hit = w_in_range && (w_head == r_key) && !r_found;
        end
        w_ctl.shift  = (r_state == S_SCAN);
        w_ctl.insert = (r_state == S_SCAN) && (r_cmd == CMD_ADD) && !r_found
                       && (CW'(r_step) == r_count);
        w_found   = r_found || w_hit;
        w_idx     = w_hit ? r_step : r_hit_idx;
        w_fkey    = w_hit ? w_head : r_hit_key;
        w_last    = (r_step == IW'(CAPACITY - 1));
        w_pos_inc = CW'(r_pos) + CW'(1);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_step    = r_step;
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_found   = r_found;
        n_hit_idx = r_hit_idx;
        n_hit_key = r_hit_key;
        n_done    = 1'b0;
        n_out     = r_out;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_word.command;
                    n_key   = w_in_key;
                    n_step  = '0;
                    n_found = 1'b0;
                    n_pos   = (CW'(r_cursor) < r_count) ? r_cursor : '0;
                    if (i_word.command != CMD_ADD && r_count == '0) begin
                        n_done = 1'b1;
                        n_out  = '0;
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_step = r_step + IW'(1);
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_step;
                    n_hit_key = w_head;
                end
                if (w_last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_out   = '0;
                    if (r_cmd == CMD_ADD && !w_found) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_out.status       = ST_OK;
                            n_out.entry_index  = 6'(r_count);
                            n_out.out_packed   = 8'(r_key[0*FIELD_BITS +: FIELD_BITS]);
                            n_out.out_connect  = 8'(r_key[1*FIELD_BITS +: FIELD_BITS]);
                            n_out.out_off_plan = 8'(r_key[2*FIELD_BITS +: FIELD_BITS]);
                            n_out.out_imagine  = 8'(r_key[3*FIELD_BITS +: FIELD_BITS]);
                            n_cursor = IW'(r_count);
                            n_count  = r_count + CW'(1);
                        end
                    end else if (!w_found) begin
                        n_out.status = ST_NOT_FOUND;
                    end else begin
                        n_out.status       = (r_cmd == CMD_ADD) ? ST_PRESENT : ST_OK;
                        n_out.entry_index  = 6'(w_idx);
                        n_out.out_packed   = 8'(w_fkey[0*FIELD_BITS +: FIELD_BITS]);
                        n_out.out_connect  = 8'(w_fkey[1*FIELD_BITS +: FIELD_BITS]);
                        n_out.out_off_plan = 8'(w_fkey[2*FIELD_BITS +: FIELD_BITS]);
                        n_out.out_imagine  = 8'(w_fkey[3*FIELD_BITS +: FIELD_BITS]);
                        if (r_cmd == CMD_NEXT) begin
                            n_cursor = (w_pos_inc >= r_count) ? '0 : IW'(w_pos_inc);
                        end else if (r_cmd == CMD_SEEK) begin
                            n_cursor = w_idx;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_pos     <= n_pos;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        r_hit_key <= n_hit_key;
        r_out     <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count != '0) |-> (CW'(r_cursor) < r_count))
        else $error("cursor outside the table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)))
        else $error("entry count jumped");

    a_no_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_done)
        else $error("result strobe during scan");

endmodule
